// ===== hdl/canid_pkg.sv =====
// Package for the CAN node-ID self-enumeration block.
// Holds item codes, mode and reply codes, register indexes, reset values and
// the control/status structs shared by the top level and the bitmap unit.
package canid_pkg;

  // Input item kinds
  localparam logic [2:0] KIND_TICK    = 3'd0;
  localparam logic [2:0] KIND_FRAME   = 3'd1;
  localparam logic [2:0] KIND_ENUMREQ = 3'd2;
  localparam logic [2:0] KIND_SETID   = 3'd3;
  localparam logic [2:0] KIND_OPCODE  = 3'd4;

  // Enumeration modes
  localparam logic [1:0] MODE_INACTIVE = 2'd0;
  localparam logic [1:0] MODE_PENDING  = 2'd1;
  localparam logic [1:0] MODE_REQUEST  = 2'd2;
  localparam logic [1:0] MODE_INPROG   = 2'd3;

  // Reply codes
  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_ERR  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_HOLD_OFF  = 3'd0;
  localparam logic [2:0] REG_RESP_WAIT = 3'd1;
  localparam logic [2:0] REG_MIN_ID    = 3'd2;
  localparam logic [2:0] REG_MAX_ID    = 3'd3;
  localparam logic [2:0] REG_INIT_ID   = 3'd4;

  // Configuration reset values
  localparam logic [15:0] RST_HOLD_OFF  = 16'd1000;
  localparam logic [15:0] RST_RESP_WAIT = 16'd100;
  localparam logic [6:0]  RST_MIN_ID    = 7'd1;
  localparam logic [6:0]  RST_MAX_ID    = 7'd99;
  localparam logic [7:0]  RST_INIT_ID   = 8'd0;

  // Value of the first bitmap byte after enumeration starts (ID zero taken)
  localparam logic [7:0] BYTE0_START = 8'h01;

  // Control from the sequencer to the bitmap unit
  typedef struct packed {
    logic       clear;
    logic       mark;
    logic [6:0] mark_id;
    logic       scan_start;
  } bm_ctl_t;

  // Status from the bitmap unit
  typedef struct packed {
    logic       done;
    logic       found;
    logic [6:0] free_id;
  } bm_sts_t;

  // One result item
  typedef struct packed {
    logic       send_rtr_request;
    logic       send_rtr_response;
    logic       id_updated;
    logic [1:0] reply;
    logic       pass_to_app;
    logic [7:0] node_id;
    logic [1:0] mode;
  } result_t;

endpackage

// ===== hdl/canid_bitmap.sv =====
// Seen-ID bitmap with mark, clear and a byte-serial free-ID scan.
// Depends on canid_pkg for the control and status structs.
module canid_bitmap #(
  parameter int BITMAP_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  canid_pkg::bm_ctl_t ctl,
  output canid_pkg::bm_sts_t sts
);

  localparam int IDX_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int CNT_W = $clog2(BITMAP_BYTES + 1);

  logic [7:0]       bytes_r [BITMAP_BYTES];
  logic             active_r;
  logic [CNT_W-1:0] idx_r;
  logic             done_r;
  logic             found_r;
  logic [6:0]       free_id_r;

  logic [7:0]       cur_byte;
  logic [2:0]       zero_bit;
  logic [3:0]       mark_byte;
  logic             mark_ok;

  // Lowest clear bit of the byte under scan
  always_comb begin
    cur_byte = bytes_r[idx_r[IDX_W-1:0]];
    zero_bit = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!cur_byte[b]) begin
        zero_bit = 3'(b);
      end
    end
  end

  assign mark_byte = ctl.mark_id[6:3];
  assign mark_ok   = (32'(mark_byte) < BITMAP_BYTES);

  // Hold bitmap, advance scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BITMAP_BYTES; i++) begin
        bytes_r[i] <= '0;
      end
      active_r  <= 1'b0;
      idx_r     <= '0;
      done_r    <= 1'b0;
      found_r   <= 1'b0;
      free_id_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.clear) begin
        for (int i = 0; i < BITMAP_BYTES; i++) begin
          bytes_r[i] <= '0;
        end
        bytes_r[0] <= canid_pkg::BYTE0_START;
      end else if (ctl.mark && mark_ok) begin
        bytes_r[mark_byte[IDX_W-1:0]][ctl.mark_id[2:0]] <= 1'b1;
      end

      if (ctl.scan_start) begin
        active_r <= 1'b1;
        idx_r    <= '0;
      end else if (active_r) begin
        if (cur_byte != 8'hFF) begin
          active_r  <= 1'b0;
          done_r    <= 1'b1;
          found_r   <= 1'b1;
          free_id_r <= 7'({idx_r[IDX_W-1:0], zero_bit});
        end else if (idx_r == CNT_W'(BITMAP_BYTES - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
          found_r  <= 1'b0;
        end else begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  assign sts.done    = done_r;
  assign sts.found   = found_r;
  assign sts.free_id = free_id_r;

`ifndef SYNTHESIS
  a_done_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !active_r)
    else $error("scan still active after done");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (32'(idx_r) < BITMAP_BYTES))
    else $error("scan index beyond bitmap");
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_start |=> active_r && !done_r)
    else $error("scan did not start");
`endif

endmodule

// ===== hdl/can_id_self_enumeration.sv =====
// Top level of the CAN node-ID self-enumeration block: sequencer, state
// registers, config port and output register. Depends on canid_pkg and
// instantiates canid_bitmap.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per transfer; the block
//   raises in_stall while it works on an item. Result channel
//   (out_valid / out_stall): exactly one result per item, held in an output
//   register until taken; a stalled result holds steady and the next item
//   is still accepted, its result waiting in the sequencer until the
//   output register frees.
//   Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; writing initial_node_id also loads the node ID.
//   Each item's result is first registered in the sequencer, then moved
//   to the output register once that register is free. A tick that
//   completes enumeration runs the byte-serial free-ID scan of the bitmap,
//   one byte per cycle, before its result is registered. A new item is
//   accepted only once the previous result has reached the output register.
//   Reset (rst_n low, synchronous): registers to defaults, mode inactive,
//   clock and bitmap cleared, output empty.
module can_id_self_enumeration #(
  parameter int BITMAP_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [10:0] in_frame_id,
  input  logic        in_is_remote,
  input  logic [3:0]  in_data_length,
  input  logic        in_want_result,
  input  logic [7:0]  in_requested_id,
  input  logic        in_validate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_rtr_request,
  output logic        out_send_rtr_response,
  output logic        out_id_updated,
  output logic [1:0]  out_reply,
  output logic        out_pass_to_app,
  output logic [7:0]  out_node_id,
  output logic [1:0]  out_mode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_t;

  state_t               state_r, state_nxt;
  logic [15:0]          hold_off_r, hold_off_nxt;
  logic [15:0]          resp_wait_r, resp_wait_nxt;
  logic [6:0]           min_id_r, min_id_nxt;
  logic [6:0]           max_id_r, max_id_nxt;
  logic [7:0]           init_id_r, init_id_nxt;
  logic [7:0]           node_id_r, node_id_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 reply_pend_r, reply_pend_nxt;
  logic [15:0]          now_r, now_nxt;
  logic [15:0]          start_r, start_nxt;
  canid_pkg::result_t   res_r, res_nxt;
  canid_pkg::result_t   out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  canid_pkg::bm_ctl_t   bm_ctl;
  canid_pkg::bm_sts_t   bm_sts;

  logic                 in_acc;
  logic [15:0]          tick_now;
  logic [15:0]          since;
  logic [6:0]           frame_node;
  logic                 scan_ok;
  logic                 setid_ok;
  canid_pkg::result_t   r;

  canid_bitmap #(.BITMAP_BYTES(BITMAP_BYTES)) u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bm_ctl),
    .sts   (bm_sts)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign tick_now   = now_r + 16'd1;
  assign since      = tick_now - start_r;
  assign frame_node = in_frame_id[6:0];

  assign scan_ok = bm_sts.found && (bm_sts.free_id >= min_id_r) &&
                   (bm_sts.free_id <= max_id_r) && (node_id_r <= {1'b0, max_id_r});
  assign setid_ok = !in_validate ||
                    ((in_requested_id >= {1'b0, min_id_r}) &&
                     (in_requested_id <= {1'b0, max_id_r}) &&
                     (node_id_r <= {1'b0, max_id_r}));

  // Sequence items, update state, load the output register
  always_comb begin
    state_nxt      = state_r;
    hold_off_nxt   = hold_off_r;
    resp_wait_nxt  = resp_wait_r;
    min_id_nxt     = min_id_r;
    max_id_nxt     = max_id_r;
    init_id_nxt    = init_id_r;
    node_id_nxt    = node_id_r;
    mode_nxt       = mode_r;
    reply_pend_nxt = reply_pend_r;
    now_nxt        = now_r;
    start_nxt      = start_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    bm_ctl         = '0;
    r              = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_HOLD;
          case (in_kind)
            canid_pkg::KIND_TICK: begin
              now_nxt = tick_now;
              if (mode_r == canid_pkg::MODE_REQUEST ||
                  (mode_r == canid_pkg::MODE_PENDING && since >= hold_off_r)) begin
                mode_nxt           = canid_pkg::MODE_INPROG;
                bm_ctl.clear       = 1'b1;
                start_nxt          = tick_now;
                r.send_rtr_request = 1'b1;
              end else if (mode_r == canid_pkg::MODE_INPROG && since >= resp_wait_r) begin
                mode_nxt          = canid_pkg::MODE_INACTIVE;
                bm_ctl.scan_start = 1'b1;
                state_nxt         = ST_SCAN;
              end
            end
            canid_pkg::KIND_FRAME: begin
              if (node_id_r != 8'd0 && {1'b0, frame_node} == node_id_r &&
                  mode_r == canid_pkg::MODE_INACTIVE) begin
                mode_nxt  = canid_pkg::MODE_PENDING;
                start_nxt = now_r;
              end else if (in_is_remote) begin
                if (in_data_length == 4'd0) begin
                  r.send_rtr_response = 1'b1;
                  if (mode_r == canid_pkg::MODE_PENDING) begin
                    start_nxt = now_r;
                  end
                end
              end else if (in_data_length == 4'd0) begin
                bm_ctl.mark    = 1'b1;
                bm_ctl.mark_id = frame_node;
              end else begin
                r.pass_to_app = 1'b1;
              end
            end
            canid_pkg::KIND_ENUMREQ: begin
              if (mode_r != canid_pkg::MODE_INPROG) begin
                mode_nxt = canid_pkg::MODE_REQUEST;
              end
              if (in_want_result) begin
                reply_pend_nxt = 1'b1;
              end
            end
            canid_pkg::KIND_SETID: begin
              if (setid_ok) begin
                node_id_nxt  = in_requested_id;
                r.id_updated = 1'b1;
              end else begin
                r.reply = canid_pkg::REPLY_ERR;
              end
            end
            canid_pkg::KIND_OPCODE: begin
              if (node_id_r > {1'b0, max_id_r}) begin
                r.reply = canid_pkg::REPLY_ERR;
              end else begin
                if (mode_r != canid_pkg::MODE_INPROG) begin
                  mode_nxt = canid_pkg::MODE_REQUEST;
                end
                reply_pend_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
          r.node_id = node_id_nxt;
          r.mode    = mode_nxt;
          res_nxt   = r;
        end
      end
      ST_SCAN: begin
        if (bm_sts.done) begin
          if (scan_ok) begin
            node_id_nxt  = {1'b0, bm_sts.free_id};
            r.id_updated = 1'b1;
          end
          if (reply_pend_r) begin
            reply_pend_nxt = 1'b0;
            r.reply        = scan_ok ? canid_pkg::REPLY_ACK : canid_pkg::REPLY_ERR;
          end
          r.node_id = node_id_nxt;
          r.mode    = mode_r;
          res_nxt   = r;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Take config writes
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        canid_pkg::REG_HOLD_OFF:  hold_off_nxt  = cfg_data;
        canid_pkg::REG_RESP_WAIT: resp_wait_nxt = cfg_data;
        canid_pkg::REG_MIN_ID:    min_id_nxt    = cfg_data[6:0];
        canid_pkg::REG_MAX_ID:    max_id_nxt    = cfg_data[6:0];
        canid_pkg::REG_INIT_ID: begin
          init_id_nxt = cfg_data[7:0];
          node_id_nxt = cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hold_off_r   <= canid_pkg::RST_HOLD_OFF;
      resp_wait_r  <= canid_pkg::RST_RESP_WAIT;
      min_id_r     <= canid_pkg::RST_MIN_ID;
      max_id_r     <= canid_pkg::RST_MAX_ID;
      init_id_r    <= canid_pkg::RST_INIT_ID;
      node_id_r    <= canid_pkg::RST_INIT_ID;
      mode_r       <= canid_pkg::MODE_INACTIVE;
      reply_pend_r <= 1'b0;
      now_r        <= '0;
      start_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hold_off_r   <= hold_off_nxt;
      resp_wait_r  <= resp_wait_nxt;
      min_id_r     <= min_id_nxt;
      max_id_r     <= max_id_nxt;
      init_id_r    <= init_id_nxt;
      node_id_r    <= node_id_nxt;
      mode_r       <= mode_nxt;
      reply_pend_r <= reply_pend_nxt;
      now_r        <= now_nxt;
      start_r      <= start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_send_rtr_request  = out_r.send_rtr_request;
  assign out_send_rtr_response = out_r.send_rtr_response;
  assign out_id_updated        = out_r.id_updated;
  assign out_reply             = out_r.reply;
  assign out_pass_to_app       = out_r.pass_to_app;
  assign out_node_id           = out_r.node_id;
  assign out_mode              = out_r.mode;

`ifndef SYNTHESIS
  a_scan_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (mode_r == canid_pkg::MODE_INACTIVE))
    else $error("mode not inactive during scan");
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    bm_sts.done |-> (state_r == ST_SCAN))
    else $error("scan done outside scan state");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("item accepted but sequencer idle");
  a_rtr_req_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.send_rtr_request) |-> (out_r.mode == canid_pkg::MODE_INPROG))
    else $error("remote request without enumeration in progress");
`endif

endmodule

// ===== dv/tb_can_id_self_enumeration.sv =====
// Self-checking testbench for can_id_self_enumeration: directed table, then
// random phases under several register settings and idle patterns.
// Depends on canid_pkg and the RTL of the block; needs no other file.
module tb_can_id_self_enumeration;

  // Kind codes outside the defined set; the block must ignore them
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  localparam int PHASE_ITEMS = 170;
  localparam int CYCLE_LIMIT = 600000;
  localparam int END_CYCLES  = 25;

  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] fid;
    logic        rem;
    logic [3:0]  dlen;
    logic        want;
    logic [7:0]  req;
    logic        val;
  } item_t;

  typedef struct packed {
    item_t              it;
    logic               chk;
    canid_pkg::result_t res;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] hold_ms;
    logic [15:0] resp_ms;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [7:0]  boot;
  } cfg_set_t;

  localparam canid_pkg::result_t NO_CHECK = '0;

  // Directed table; rows with chk set carry a hand-derived expectation
  dir_row_t steps [25] = '{
    '{'{canid_pkg::KIND_TICK, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd0, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_FRAME, 11'h7FF, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b1, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd0, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_FRAME, 11'h000, 1'b1, 4'd8, 1'b1, 8'hFF, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd0, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_FRAME, 11'h155, 1'b0, 4'd15, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b1, 8'd0, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_FRAME, 11'h780, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd0, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_SETID, 11'h000, 1'b0, 4'd0, 1'b0, 8'hFF, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_ERR, 1'b0, 8'd0, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_SETID, 11'h000, 1'b0, 4'd0, 1'b0, 8'hFF, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b1, canid_pkg::REPLY_NONE, 1'b0, 8'd255, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_OPCODE, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_ERR, 1'b0, 8'd255, canid_pkg::MODE_INACTIVE}},
    '{'{KIND_UNUSED_LO, 11'h7FF, 1'b1, 4'd15, 1'b1, 8'hFF, 1'b1}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd255, canid_pkg::MODE_INACTIVE}},
    '{'{KIND_UNUSED_HI, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd255, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_SETID, 11'h000, 1'b0, 4'd0, 1'b0, 8'h03, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b1, canid_pkg::REPLY_NONE, 1'b0, 8'd3, canid_pkg::MODE_INACTIVE}},
    '{'{canid_pkg::KIND_FRAME, 11'h583, 1'b0, 4'd2, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd3, canid_pkg::MODE_PENDING}},
    '{'{canid_pkg::KIND_FRAME, 11'h010, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b1, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd3, canid_pkg::MODE_PENDING}},
    '{'{canid_pkg::KIND_ENUMREQ, 11'h000, 1'b0, 4'd0, 1'b1, 8'h00, 1'b0}, 1'b1,
      '{1'b0, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd3, canid_pkg::MODE_REQUEST}},
    '{'{canid_pkg::KIND_TICK, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b1,
      '{1'b1, 1'b0, 1'b0, canid_pkg::REPLY_NONE, 1'b0, 8'd3, canid_pkg::MODE_INPROG}},
    '{'{canid_pkg::KIND_FRAME, 11'h001, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_FRAME, 11'h602, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_ENUMREQ, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_FRAME, 11'h003, 1'b1, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_TICK, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_TICK, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_SETID, 11'h000, 1'b0, 4'd0, 1'b0, 8'd50, 1'b1}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_OPCODE, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_FRAME, 11'h7FF, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{canid_pkg::KIND_TICK, 11'h000, 1'b0, 4'd0, 1'b0, 8'h00, 1'b0}, 1'b0, NO_CHECK}
  };

  // Register settings per random phase, extremes included
  cfg_set_t phase_cfg [6] = '{
    '{16'd0,     16'd0,     7'd0,   7'd127, 8'd0},
    '{16'd3,     16'd10,    7'd1,   7'd99,  8'd5},
    '{16'd65535, 16'd65535, 7'd127, 7'd127, 8'd255},
    '{16'd2,     16'd5,     7'd10,  7'd40,  8'd20},
    '{16'd1,     16'd3,     7'd0,   7'd0,   8'd0},
    '{16'd5,     16'd30,    7'd1,   7'd127, 8'd127}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = canid_pkg::KIND_TICK;
  logic [10:0] in_frame_id = '0;
  logic        in_is_remote = 1'b0;
  logic [3:0]  in_data_length = '0;
  logic        in_want_result = 1'b0;
  logic [7:0]  in_requested_id = '0;
  logic        in_validate = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_send_rtr_request;
  logic        out_send_rtr_response;
  logic        out_id_updated;
  logic [1:0]  out_reply;
  logic        out_pass_to_app;
  logic [7:0]  out_node_id;
  logic [1:0]  out_mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = canid_pkg::REG_HOLD_OFF;
  logic [15:0] cfg_data = '0;

  // Mirror of the engine state and its registers
  logic [7:0]   id_now;
  logic [1:0]   mode_now;
  logic         ack_owed;
  logic [15:0]  ms_now;
  logic [15:0]  ms_start;
  logic [127:0] seen_ids;
  logic [15:0]  hold_ms;
  logic [15:0]  wait_ms;
  logic [6:0]   lo_id;
  logic [6:0]   hi_id;
  logic [7:0]   boot_id;

  canid_pkg::result_t due_results [$];
  canid_pkg::result_t last_pred;
  int snd_pct = 0;
  int rcv_pct = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_done = 0;
  int n_settings = 0;
  int unsigned cycle_count = 0;

  can_id_self_enumeration u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_frame_id          (in_frame_id),
    .in_is_remote         (in_is_remote),
    .in_data_length       (in_data_length),
    .in_want_result       (in_want_result),
    .in_requested_id      (in_requested_id),
    .in_validate          (in_validate),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_send_rtr_request (out_send_rtr_request),
    .out_send_rtr_response(out_send_rtr_response),
    .out_id_updated       (out_id_updated),
    .out_reply            (out_reply),
    .out_pass_to_app      (out_pass_to_app),
    .out_node_id          (out_node_id),
    .out_mode             (out_mode),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Take an ID if it passes the dynamic-range checks (when asked to check)
  function automatic bit accept_id(input logic [7:0] id, input bit check);
    if (check && (id < lo_id || id > hi_id || id_now > hi_id)) return 1'b0;
    id_now = id;
    return 1'b1;
  endfunction

  // Advance the mirrored engine by one item and return its result
  function automatic canid_pkg::result_t next_enum_result(input item_t it);
    canid_pkg::result_t r;
    logic [15:0]        since;
    logic [6:0]         fid7;
    int                 free_id;
    bit                 ok;
    r = '0;
    fid7 = it.fid[6:0];
    case (it.kind)
      canid_pkg::KIND_TICK: begin
        ms_now = ms_now + 16'd1;
        since = ms_now - ms_start;
        if (mode_now == canid_pkg::MODE_REQUEST ||
            (mode_now == canid_pkg::MODE_PENDING && since >= hold_ms)) begin
          // start: clear the map, ID zero is never free
          mode_now = canid_pkg::MODE_INPROG;
          seen_ids = '0;
          seen_ids[7:0] = canid_pkg::BYTE0_START;
          r.send_rtr_request = 1'b1;
          ms_start = ms_now;
        end else if (mode_now == canid_pkg::MODE_INPROG && since >= wait_ms) begin
          // complete: lowest clear bit is the candidate ID
          mode_now = canid_pkg::MODE_INACTIVE;
          n_done++;
          free_id = -1;
          for (int i = 127; i >= 0; i--) if (!seen_ids[i]) free_id = i;
          ok = (free_id >= 0) && accept_id(8'(free_id), 1'b1);
          r.id_updated = ok;
          if (ack_owed) begin
            ack_owed = 1'b0;
            r.reply = ok ? canid_pkg::REPLY_ACK : canid_pkg::REPLY_ERR;
          end
        end
      end
      canid_pkg::KIND_FRAME: begin
        if (id_now != 8'd0 && {1'b0, fid7} == id_now &&
            mode_now == canid_pkg::MODE_INACTIVE) begin
          mode_now = canid_pkg::MODE_PENDING;
          ms_start = ms_now;
        end else if (it.rem) begin
          if (it.dlen == 4'd0) begin
            r.send_rtr_response = 1'b1;
            if (mode_now == canid_pkg::MODE_PENDING) ms_start = ms_now;
          end
        end else if (it.dlen == 4'd0) begin
          seen_ids[fid7] = 1'b1;
        end else begin
          r.pass_to_app = 1'b1;
        end
      end
      canid_pkg::KIND_ENUMREQ: begin
        if (mode_now != canid_pkg::MODE_INPROG) mode_now = canid_pkg::MODE_REQUEST;
        if (it.want) ack_owed = 1'b1;
      end
      canid_pkg::KIND_SETID: begin
        if (accept_id(it.req, it.val)) r.id_updated = 1'b1;
        else r.reply = canid_pkg::REPLY_ERR;
      end
      canid_pkg::KIND_OPCODE: begin
        if (id_now > hi_id) begin
          r.reply = canid_pkg::REPLY_ERR;
        end else begin
          if (mode_now != canid_pkg::MODE_INPROG) mode_now = canid_pkg::MODE_REQUEST;
          ack_owed = 1'b1;
        end
      end
      default: ;
    endcase
    r.node_id = id_now;
    r.mode = mode_now;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
  endtask

  task automatic check_result(input canid_pkg::result_t got, input canid_pkg::result_t want);
    if (got.send_rtr_request !== want.send_rtr_request)
      flag_mismatch("send_rtr_request", got.send_rtr_request, want.send_rtr_request);
    if (got.send_rtr_response !== want.send_rtr_response)
      flag_mismatch("send_rtr_response", got.send_rtr_response, want.send_rtr_response);
    if (got.id_updated !== want.id_updated)
      flag_mismatch("id_updated", got.id_updated, want.id_updated);
    if (got.reply !== want.reply)
      flag_mismatch("reply", got.reply, want.reply);
    if (got.pass_to_app !== want.pass_to_app)
      flag_mismatch("pass_to_app", got.pass_to_app, want.pass_to_app);
    if (got.node_id !== want.node_id)
      flag_mismatch("node_id", got.node_id, want.node_id);
    if (got.mode !== want.mode)
      flag_mismatch("mode", got.mode, want.mode);
  endtask

  // Drive one item, wait for its transfer, then queue its expected result
  task automatic send_item(input item_t it, input bit use_row,
                           input canid_pkg::result_t row_res);
    canid_pkg::result_t p;
    while (roll(snd_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= it.kind;
    in_frame_id     <= it.fid;
    in_is_remote    <= it.rem;
    in_data_length  <= it.dlen;
    in_want_result  <= it.want;
    in_requested_id <= it.req;
    in_validate     <= it.val;
    do @(posedge clk); while (in_stall);
    p = next_enum_result(it);
    last_pred = p;
    due_results.push_back(use_row ? row_res : p);
    n_items++;
  endtask

  // Write one register; the caller drops cfg_valid after the last write
  task automatic cfg_put(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      canid_pkg::REG_HOLD_OFF:  hold_ms = data;
      canid_pkg::REG_RESP_WAIT: wait_ms = data;
      canid_pkg::REG_MIN_ID:    lo_id = data[6:0];
      canid_pkg::REG_MAX_ID:    hi_id = data[6:0];
      canid_pkg::REG_INIT_ID: begin
        boot_id = data[7:0];
        id_now = data[7:0];
      end
      default: ;
    endcase
  endtask

  task automatic load_config(input cfg_set_t c);
    cfg_put(canid_pkg::REG_HOLD_OFF, c.hold_ms);
    cfg_put(canid_pkg::REG_RESP_WAIT, c.resp_ms);
    cfg_put(canid_pkg::REG_MIN_ID, 16'(c.lo));
    cfg_put(canid_pkg::REG_MAX_ID, 16'(c.hi));
    cfg_put(canid_pkg::REG_INIT_ID, 16'(c.boot));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Wait until every queued result has been taken and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random item, biased toward sequences that run enumeration end to end
  function automatic item_t make_item();
    item_t it;
    int    r;
    int    sub;
    it.fid  = 11'($urandom);
    it.rem  = 1'($urandom);
    it.dlen = 4'($urandom);
    it.want = 1'($urandom);
    it.req  = 8'($urandom);
    it.val  = 1'($urandom);
    r = $urandom_range(99, 0);
    if (r < 38) begin
      it.kind = canid_pkg::KIND_TICK;
    end else if (r < 75) begin
      it.kind = canid_pkg::KIND_FRAME;
      sub = $urandom_range(99, 0);
      if (sub < 10) begin
        // own ID on the bus
        if (id_now < 8'd128) it.fid[6:0] = id_now[6:0];
      end else if (sub < 30) begin
        it.rem = 1'b1;
        if (roll(50)) it.dlen = 4'd0;
      end else if (sub < 80) begin
        // mark, mostly low IDs so the free-ID search lands in varied places
        it.rem = 1'b0;
        it.dlen = 4'd0;
        if (roll(80)) it.fid[6:0] = 7'($urandom_range(23, 0));
      end else begin
        it.rem = 1'b0;
        it.dlen = 4'($urandom_range(15, 1));
      end
    end else if (r < 84) begin
      it.kind = canid_pkg::KIND_ENUMREQ;
    end else if (r < 90) begin
      it.kind = canid_pkg::KIND_SETID;
      if (roll(80)) it.req = 8'($urandom_range(30, 0));
    end else if (r < 97) begin
      it.kind = canid_pkg::KIND_OPCODE;
    end else begin
      it.kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    end
    return it;
  endfunction

  // Run one enumeration with every ID marked, so no free ID is left
  task automatic fill_bitmap();
    item_t it;
    int    guard;
    guard = 0;
    do begin
      if (mode_now != canid_pkg::MODE_INPROG && mode_now != canid_pkg::MODE_REQUEST) begin
        it = '0;
        it.kind = canid_pkg::KIND_ENUMREQ;
        it.want = 1'b1;
        send_item(it, 1'b0, NO_CHECK);
      end
      it = '0;
      it.kind = canid_pkg::KIND_TICK;
      send_item(it, 1'b0, NO_CHECK);
      guard++;
    end while (!last_pred.send_rtr_request && guard < 100);
    for (int id = 1; id < 128; id++) begin
      it = '0;
      it.kind = canid_pkg::KIND_FRAME;
      it.fid[10:7] = 4'($urandom);
      it.fid[6:0] = 7'(id);
      send_item(it, 1'b0, NO_CHECK);
    end
    guard = 0;
    while (mode_now == canid_pkg::MODE_INPROG && guard < 200) begin
      it = '0;
      it.kind = canid_pkg::KIND_TICK;
      send_item(it, 1'b0, NO_CHECK);
      guard++;
    end
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= roll(rcv_pct);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (due_results.size() == 0)
        flag_mismatch("result with nothing expected", out_node_id, -1);
      else
        check_result({out_send_rtr_request, out_send_rtr_response, out_id_updated,
                      out_reply, out_pass_to_app, out_node_id, out_mode},
                     due_results.pop_front());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("FAIL can_id_self_enumeration");
      $finish;
    end
  end

  initial begin
    hold_ms  = canid_pkg::RST_HOLD_OFF;
    wait_ms  = canid_pkg::RST_RESP_WAIT;
    lo_id    = canid_pkg::RST_MIN_ID;
    hi_id    = canid_pkg::RST_MAX_ID;
    boot_id  = canid_pkg::RST_INIT_ID;
    id_now   = canid_pkg::RST_INIT_ID;
    mode_now = canid_pkg::MODE_INACTIVE;
    ack_owed = 1'b0;
    ms_now   = '0;
    ms_start = '0;
    seen_ids = '0;
    last_pred = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table with short timers so enumeration completes within it
    load_config('{16'd1, 16'd2, canid_pkg::RST_MIN_ID, canid_pkg::RST_MAX_ID,
                  canid_pkg::RST_INIT_ID});
    foreach (steps[i]) send_item(steps[i].it, steps[i].chk, steps[i].res);

    // Random phases: new settings and idle pattern each time
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 59; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 59; end
        default: begin snd_pct = 15; rcv_pct = 15; end
      endcase
      load_config(phase_cfg[ph]);
      if (ph == 1) fill_bitmap();
      repeat (PHASE_ITEMS) send_item(make_item(), 1'b0, NO_CHECK);
    end

    // Let the pipeline empty, then report
    drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("Ran %0d items over %0d register settings; %0d results checked.",
             n_items, n_settings, n_results);
    $display("Enumeration completed %0d times, one of them with a full ID map.", n_done);
    if (n_errors == 0 && due_results.size() == 0)
      $display("PASS can_id_self_enumeration");
    else
      $display("FAIL can_id_self_enumeration");
    $finish;
  end

endmodule
